/* rtl/core/ukstep_pkg.sv */
// ----------------------------------------------------------------------------
// ukstep_pkg
// Shared types, register indexes and constants of the unicycle step block.
// ----------------------------------------------------------------------------
package ukstep_pkg;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_STEP    = 2'd0;
    localparam cmd_t CMD_STOP    = 2'd1;
    localparam cmd_t CMD_RESTART = 2'd2;

    localparam logic [2:0] REG_MAX_VEL   = 3'd0;
    localparam logic [2:0] REG_MAX_YAW   = 3'd1;
    localparam logic [2:0] REG_MIN_RAD   = 3'd2;
    localparam logic [2:0] REG_START_X   = 3'd3;
    localparam logic [2:0] REG_START_Y   = 3'd4;
    localparam logic [2:0] REG_START_HD  = 3'd5;

    // quarter-wave sine polynomial, Q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42047;
    localparam logic [12:0] SIN_C = 13'd4640;
    localparam logic [19:0] TWO_PI_Q16 = 20'd411775;

    localparam logic [16:0] THR_ONE   = 17'd16384;
    localparam logic signed [15:0] THR_TENTH = 16'sd1638;

    typedef struct packed {
        logic [19:0] vel_full;
        logic [15:0] max_yaw_rate;
        logic [19:0] radius_min;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [15:0] heading_home;
    } cfg_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [15:0]        dt;
        logic signed [15:0] thr;
        logic signed [17:0] yaw;
        logic [17:0]        ayaw;
        logic               lim_fail;
        logic               rad_need;
    } item_t;

    typedef struct packed {
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic [15:0]        heading;
        logic signed [20:0] speed;
        logic               rejected;
    } res_t;

endpackage

/* rtl/core/ukstep_front.sv */
// ----------------------------------------------------------------------------
// ukstep_front
// Takes requests off the input stream, decodes them and runs the limit checks.
// ----------------------------------------------------------------------------
module ukstep_front
(
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [55:0]        s_axis_tdata,
    input  logic [1:0]         s_axis_tuser,
    input  ukstep_pkg::cfg_t   cfg,
    input  logic               q_full,
    output logic               q_push,
    output ukstep_pkg::item_t  q_item
);
    import ukstep_pkg::*;

    logic signed [15:0] thr;
    logic signed [17:0] yaw;
    logic [16:0]        athr;
    logic [17:0]        ayaw;

    always_comb
    begin
        thr  = s_axis_tdata[31:16];
        yaw  = s_axis_tdata[49:32];
        athr = thr[15] ? (17'd0 - {thr[15], thr}) : {1'b0, thr};
        ayaw = yaw[17] ? (18'd0 - yaw) : yaw;

        q_item.cmd      = s_axis_tuser;
        q_item.dt       = s_axis_tdata[15:0];
        q_item.thr      = thr;
        q_item.yaw      = yaw;
        q_item.ayaw     = ayaw;
        q_item.lim_fail = (athr > THR_ONE) || (ayaw > {2'b0, cfg.max_yaw_rate});
        // radius test only for real forward throttle with some turn
        q_item.rad_need = (thr > THR_TENTH) && (ayaw != 18'd0);
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

endmodule

/* rtl/core/ukstep_queue.sv */
// ----------------------------------------------------------------------------
// ukstep_queue
// Two-entry request queue between the decode front and the step sequencer.
// ----------------------------------------------------------------------------
module ukstep_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ukstep_pkg::item_t  item_in,
    output logic               full,
    input  logic               pop,
    output ukstep_pkg::item_t  item_out,
    output logic               empty
);
    import ukstep_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item_in;
    end

    assign item_out = mem_reg[rd_ptr_reg];
    assign full     = count_reg[1];
    assign empty    = (count_reg == 2'd0);

endmodule

/* rtl/core/ukstep_back.sv */
// ----------------------------------------------------------------------------
// ukstep_back
// Step sequencer: one shared multiplier runs radius test, heading, speed,
// sine/cosine and the position update, then a result register feeds the output.
// ----------------------------------------------------------------------------
module ukstep_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  ukstep_pkg::cfg_t   cfg,
    input  logic               q_empty,
    input  ukstep_pkg::item_t  q_item,
    output logic               q_pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output ukstep_pkg::res_t   res
);
    import ukstep_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_R1   = 4'd1;
    localparam logic [3:0] ST_R2   = 4'd2;
    localparam logic [3:0] ST_H    = 4'd3;
    localparam logic [3:0] ST_V    = 4'd4;
    localparam logic [3:0] ST_TA   = 4'd5;
    localparam logic [3:0] ST_TB   = 4'd6;
    localparam logic [3:0] ST_TC   = 4'd7;
    localparam logic [3:0] ST_TD   = 4'd8;
    localparam logic [3:0] ST_TE   = 4'd9;
    localparam logic [3:0] ST_TF   = 4'd10;
    localparam logic [3:0] ST_TG   = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    logic [3:0]         state_reg, state_next;
    item_t              cur_reg;
    logic signed [15:0] thr_reg;
    logic [31:0]        x_reg, y_reg;
    logic [15:0]        hd_reg;
    logic signed [20:0] spd_reg;
    logic signed [57:0] prod_reg;
    logic [14:0]        z_reg, z2_reg;
    logic               neg_reg, ph_reg, rej_reg;
    logic               ov_reg;
    res_t               res_reg;

    logic signed [36:0] ma;
    logic signed [20:0] mb;
    logic signed [57:0] mp;

    logic               rad_fail, ok;
    logic signed [17:0] yaw_eff;
    logic [15:0]        angle;
    logic [14:0]        z_n;
    logic [15:0]        t1;
    logic [16:0]        t2;
    logic [15:0]        s_mag;
    logic signed [16:0] cs;
    logic signed [57:0] rnd14, rnd16, rnd22;
    logic               out_free;

    always_comb
    begin
        rad_fail = cur_reg.rad_need &&
                   (spd_reg[20] || ({5'b0, spd_reg[19:0], 32'b0} < prod_reg[56:0]));
        ok       = !cur_reg.lim_fail && !rad_fail;
        yaw_eff  = ok ? cur_reg.yaw : 18'sd0;

        angle = ph_reg ? hd_reg : (hd_reg + 16'd16384);
        z_n   = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
        t1    = SIN_B - {3'b0, prod_reg[26:14]};
        t2    = SIN_A - {1'b0, prod_reg[29:14]};
        s_mag = prod_reg[31:16];
        cs    = neg_reg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

        // truncation toward zero: bias negative values before the shift
        rnd14 = prod_reg + (prod_reg[57] ? 58'sd16383 : 58'sd0);
        rnd16 = prod_reg + (prod_reg[57] ? 58'sd65535 : 58'sd0);
        rnd22 = prod_reg + (prod_reg[57] ? 58'sd4194303 : 58'sd0);

        ma = 37'sd0;
        mb = 21'sd0;
        case (state_reg)
            ST_R1:
            begin
                ma = $signed({17'b0, cfg.radius_min});
                mb = $signed({3'b0, cur_reg.ayaw});
            end
            ST_R2:
            begin
                ma = $signed({1'b0, prod_reg[35:0]});
                mb = $signed({1'b0, TWO_PI_Q16});
            end
            ST_H:
            begin
                ma = {{19{yaw_eff[17]}}, yaw_eff};
                mb = $signed({5'b0, cur_reg.dt});
            end
            ST_V:
            begin
                ma = {{21{thr_reg[15]}}, thr_reg};
                mb = $signed({1'b0, cfg.vel_full});
            end
            ST_TA:
            begin
                ma = $signed({22'b0, z_n});
                mb = $signed({6'b0, z_n});
            end
            ST_TB:
            begin
                ma = $signed({22'b0, prod_reg[28:14]});
                mb = $signed({8'b0, SIN_C});
            end
            ST_TC:
            begin
                ma = $signed({21'b0, t1});
                mb = $signed({6'b0, z2_reg});
            end
            ST_TD:
            begin
                ma = $signed({20'b0, t2});
                mb = $signed({6'b0, z_reg});
            end
            ST_TE:
            begin
                ma = {{16{spd_reg[20]}}, spd_reg};
                mb = {{4{cs[16]}}, cs};
            end
            ST_TF:
            begin
                ma = prod_reg[36:0];
                mb = $signed({5'b0, cur_reg.dt});
            end
            default:
            begin
                ma = 37'sd0;
                mb = 21'sd0;
            end
        endcase
        mp = ma * mb;
    end

    assign out_free = !ov_reg || m_axis_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                    state_next = (q_item.cmd == CMD_STEP) ? ST_R1 : ST_OUT;
            end
            ST_R1:   state_next = ST_R2;
            ST_R2:   state_next = ST_H;
            ST_H:    state_next = ST_V;
            ST_V:    state_next = ST_TA;
            ST_TA:   state_next = ST_TB;
            ST_TB:   state_next = ST_TC;
            ST_TC:   state_next = ST_TD;
            ST_TD:   state_next = ST_TE;
            ST_TE:   state_next = ST_TF;
            ST_TF:   state_next = ST_TG;
            ST_TG:   state_next = ph_reg ? ST_OUT : ST_TA;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x_reg     <= 32'd0;
            y_reg     <= 32'd0;
            hd_reg    <= 16'd0;
            spd_reg   <= 21'sd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && !q_empty)
            begin
                case (q_item.cmd)
                    CMD_STOP:
                        spd_reg <= 21'sd0;
                    CMD_RESTART:
                    begin
                        x_reg   <= cfg.start_x;
                        y_reg   <= cfg.start_y;
                        hd_reg  <= cfg.heading_home;
                        spd_reg <= 21'sd0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_V)
                hd_reg <= hd_reg + rnd16[31:16];
            if (state_reg == ST_TA && !ph_reg)
                spd_reg <= rnd14[34:14];
            if (state_reg == ST_TG)
            begin
                if (ph_reg)
                    y_reg <= y_reg + rnd22[53:22];
                else
                    x_reg <= x_reg + rnd22[53:22];
            end
            if (state_reg == ST_OUT && out_free)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mp;
        if (state_reg == ST_IDLE && !q_empty)
        begin
            cur_reg <= q_item;
            rej_reg <= 1'b0;
        end
        if (state_reg == ST_H)
        begin
            thr_reg <= ok ? cur_reg.thr : 16'sd0;
            rej_reg <= !ok;
        end
        if (state_reg == ST_V)
            ph_reg <= 1'b0;
        if (state_reg == ST_TA)
        begin
            z_reg   <= z_n;
            neg_reg <= angle[15];
        end
        if (state_reg == ST_TB)
            z2_reg <= prod_reg[28:14];
        if (state_reg == ST_TG)
            ph_reg <= 1'b1;
        if (state_reg == ST_OUT && out_free)
        begin
            res_reg.pos_x    <= x_reg;
            res_reg.pos_y    <= y_reg;
            res_reg.heading  <= hd_reg;
            res_reg.speed    <= spd_reg;
            res_reg.rejected <= rej_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign res           = res_reg;

endmodule

/* rtl/core/unicycle_kinematic_step_top.sv */
// ----------------------------------------------------------------------------
// unicycle_kinematic_step_top
// Fixed-point unicycle dead reckoning: limit checks, heading, speed and pose.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: tuser = command (step, stop, restart),
//   tdata = dt, throttle, yaw rate. m_axis returns one result per request:
//   tdata = x, y, heading, speed; tuser = rejected flag.
//   cfg_we/cfg_addr/cfg_data write the six setup registers; write them only
//   while no request is in flight.
//   a request is written into the two-entry queue, and the sequencer
//   takes it from there while idle. a step runs through the single shared
//   multiplier (radius test, heading, speed, cosine and sine pass), then
//   its result goes to the result register; stop, restart and the unused
//   code go straight to it. the sequencer handles one request at a time.
//   the result register holds a finished result while the receiver stalls;
//   the queue keeps taking requests until it is full, then tready drops.
//   reset puts the pose at the reset start values, speed at zero and both
//   channels empty.
// ----------------------------------------------------------------------------
module unicycle_kinematic_step_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // time_step, throttle, yaw_request
    input  logic [1:0]   s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // pos_x, pos_y, heading_out, speed_out
    output logic         m_axis_tuser,   // rejected
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_data
);
    import ukstep_pkg::*;

    cfg_t  cfg_reg;
    item_t f_item, q_head;
    res_t  res;
    logic  q_push, q_full, q_pop, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vel_full      <= 20'd25600;
            cfg_reg.max_yaw_rate  <= 16'd16384;
            cfg_reg.radius_min    <= 20'd5120;
            cfg_reg.start_x       <= 32'd0;
            cfg_reg.start_y       <= 32'd0;
            cfg_reg.heading_home  <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_VEL:  cfg_reg.vel_full     <= cfg_data[19:0];
                REG_MAX_YAW:  cfg_reg.max_yaw_rate <= cfg_data[15:0];
                REG_MIN_RAD:  cfg_reg.radius_min   <= cfg_data[19:0];
                REG_START_X:  cfg_reg.start_x      <= cfg_data;
                REG_START_Y:  cfg_reg.start_y      <= cfg_data;
                REG_START_HD: cfg_reg.heading_home <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ukstep_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (f_item)
    );

    ukstep_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (f_item),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (q_head),
        .empty    (q_empty)
    );

    ukstep_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_item        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .res           (res)
    );

    assign m_axis_tdata = {3'b0, res.speed, res.heading, res.pos_y, res.pos_x};
    assign m_axis_tuser = res.rejected;

    a_rej_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (res.speed == 21'sd0))
        else $error("rejected step reports nonzero speed");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("request queue read while empty");

endmodule
